// ===== design/cpec_pkg.sv =====
`default_nettype none
package cpec_pkg;

  // quotient bits: |velocity change| stays below 2^20 on a hit
  localparam int unsigned QW   = 20;
  localparam int unsigned REMW = 35;
  localparam int unsigned NUMW = 52;
  localparam int unsigned DENW = 35;

  typedef struct packed {
    logic signed [15:0] a_pos_x;
    logic signed [15:0] a_pos_y;
    logic signed [15:0] a_vel_x;
    logic signed [15:0] a_vel_y;
    logic        [11:0] a_radius;
    logic        [7:0]  a_mass;
    logic signed [15:0] b_pos_x;
    logic signed [15:0] b_pos_y;
    logic signed [15:0] b_vel_x;
    logic signed [15:0] b_vel_y;
    logic        [11:0] b_radius;
    logic        [7:0]  b_mass;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] new_a_vel_x;
    logic signed [15:0] new_a_vel_y;
    logic signed [15:0] new_b_vel_x;
    logic signed [15:0] new_b_vel_y;
    logic               clipped;
  } out_t;

  // what travels alongside the dividers
  typedef struct packed {
    logic               hit;
    logic               pass;
    logic               sx;
    logic               sy;
    logic signed [15:0] axv;
    logic signed [15:0] ayv;
    logic signed [15:0] bxv;
    logic signed [15:0] byv;
  } side_t;

endpackage
`default_nettype wire

// ===== design/cpec_div.sv =====
`default_nettype none
// Unsigned restoring divider, one quotient bit per register stage.
// Needs num < den * 2^QW; every register advances only while en_i is high.
module cpec_div (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [cpec_pkg::NUMW-1:0]      num_i,
  input  wire logic [cpec_pkg::DENW-1:0]      den_i,
  output logic      [cpec_pkg::QW-1:0]        quo_o
);

  logic [cpec_pkg::REMW-1:0] rem_q [0:cpec_pkg::QW];
  logic [cpec_pkg::QW-1:0]   low_q [0:cpec_pkg::QW];
  logic [cpec_pkg::DENW-1:0] den_q [0:cpec_pkg::QW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= cpec_pkg::REMW'(num_i[cpec_pkg::NUMW-1:cpec_pkg::QW]);
      low_q[0] <= num_i[cpec_pkg::QW-1:0];
      den_q[0] <= den_i;
    end
  end

  for (genvar i = 0; i < cpec_pkg::QW; i++) begin : g_step
    logic [cpec_pkg::REMW:0] sh;
    logic [cpec_pkg::REMW:0] trial;
    logic [cpec_pkg::REMW-1:0] rem_d;
    logic qbit;

    always_comb begin
      sh    = {rem_q[i], low_q[i][cpec_pkg::QW-1]};
      trial = sh - {1'b0, den_q[i]};
      qbit  = !trial[cpec_pkg::REMW];
      rem_d = qbit ? trial[cpec_pkg::REMW-1:0] : sh[cpec_pkg::REMW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= rem_d;
        low_q[i+1] <= {low_q[i][cpec_pkg::QW-2:0], qbit};
        den_q[i+1] <= den_q[i];
      end
    end
  end

  assign quo_o = low_q[cpec_pkg::QW];

endmodule
`default_nettype wire

// ===== design/circle_pair_elastic_collision.sv =====
`default_nettype none
// channel | direction | payload         | handshake
// input   | in        | in_data_i  in_t | valid_i,  stall_o
// output  | out       | out_data_o out_t| valid_o,  stall_i
//
// One item per cycle, unless the output is stalled, through 5 arithmetic stages,
// a 21-stage bit-per-stage divider and an output register. The whole pipe holds
// while the output item is stalled; stall_o is valid_o && stall_i.
// Reset clears only the valid bits.
module circle_pair_elastic_collision (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 stall_o,
  input  wire cpec_pkg::in_t   in_data_i,
  output logic                 valid_o,
  input  wire logic            stall_i,
  output cpec_pkg::out_t       out_data_o
);

  localparam int unsigned QW = cpec_pkg::QW;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic vd_q [0:QW];

  assign en      = !(vo_q && stall_i);
  assign stall_o = vo_q && stall_i;

  // stage 1: differences
  logic signed [16:0] rx_q, ry_q, vx_q, vy_q;
  logic        [12:0] rs_q;
  logic        [7:0]  am1_q, bm1_q;
  logic signed [15:0] axv1_q, ayv1_q, bxv1_q, byv1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q   <= {in_data_i.b_pos_x[15], in_data_i.b_pos_x}
              - {in_data_i.a_pos_x[15], in_data_i.a_pos_x};
      ry_q   <= {in_data_i.b_pos_y[15], in_data_i.b_pos_y}
              - {in_data_i.a_pos_y[15], in_data_i.a_pos_y};
      vx_q   <= {in_data_i.a_vel_x[15], in_data_i.a_vel_x}
              - {in_data_i.b_vel_x[15], in_data_i.b_vel_x};
      vy_q   <= {in_data_i.a_vel_y[15], in_data_i.a_vel_y}
              - {in_data_i.b_vel_y[15], in_data_i.b_vel_y};
      rs_q   <= {1'b0, in_data_i.a_radius} + {1'b0, in_data_i.b_radius};
      am1_q  <= in_data_i.a_mass;
      bm1_q  <= in_data_i.b_mass;
      axv1_q <= in_data_i.a_vel_x;
      ayv1_q <= in_data_i.a_vel_y;
      bxv1_q <= in_data_i.b_vel_x;
      byv1_q <= in_data_i.b_vel_y;
    end
  end

  // stage 2: products
  logic signed [33:0] pxx_q, pyy_q, pdx_q, pdy_q;
  logic        [25:0] rs2_q;
  logic signed [16:0] rx2_q, ry2_q;
  logic        [7:0]  am2_q, bm2_q;
  logic signed [15:0] axv2_q, ayv2_q, bxv2_q, byv2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxx_q  <= rx_q * rx_q;
      pyy_q  <= ry_q * ry_q;
      pdx_q  <= vx_q * rx_q;
      pdy_q  <= vy_q * ry_q;
      rs2_q  <= rs_q * rs_q;
      rx2_q  <= rx_q;
      ry2_q  <= ry_q;
      am2_q  <= am1_q;
      bm2_q  <= bm1_q;
      axv2_q <= axv1_q;
      ayv2_q <= ayv1_q;
      bxv2_q <= bxv1_q;
      byv2_q <= byv1_q;
    end
  end

  // stage 3: closing speed, distance, hit test
  logic signed [34:0] dot;
  logic        [34:0] mag2;
  logic        [8:0]  msum;
  logic signed [16:0] rxa, rya;
  logic               hit3;

  always_comb begin
    dot  = {pdx_q[33], pdx_q} + {pdy_q[33], pdy_q};
    mag2 = 35'(unsigned'({pxx_q[33], pxx_q} + {pyy_q[33], pyy_q}));
    msum = {1'b0, am2_q} + {1'b0, bm2_q};
    rxa  = rx2_q[16] ? -rx2_q : rx2_q;
    rya  = ry2_q[16] ? -ry2_q : ry2_q;
    hit3 = !dot[34] && (dot != '0) && (mag2 <= {9'b0, rs2_q});
  end

  logic        [29:0] dm_q;
  logic        [25:0] mag3_q;
  logic        [8:0]  msum3_q;
  logic        [12:0] rxm3_q, rym3_q;
  logic        [7:0]  am3_q, bm3_q;
  cpec_pkg::side_t    sd3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_q       <= dot[29:0];
      mag3_q     <= mag2[25:0];
      msum3_q    <= msum;
      rxm3_q     <= rxa[12:0];
      rym3_q     <= rya[12:0];
      am3_q      <= am2_q;
      bm3_q      <= bm2_q;
      sd3_q.hit  <= hit3;
      sd3_q.pass <= !hit3 || (msum == '0);
      sd3_q.sx   <= rx2_q[16];
      sd3_q.sy   <= ry2_q[16];
      sd3_q.axv  <= axv2_q;
      sd3_q.ayv  <= ayv2_q;
      sd3_q.bxv  <= bxv2_q;
      sd3_q.byv  <= byv2_q;
    end
  end

  // stage 4: impulse scale and denominator
  logic [37:0] ka_q, kb_q;
  logic [34:0] den4_q;
  logic [12:0] rxm4_q, rym4_q;
  cpec_pkg::side_t sd4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ka_q   <= 38'(bm3_q) * 38'(dm_q);
      kb_q   <= 38'(am3_q) * 38'(dm_q);
      den4_q <= 35'(msum3_q) * 35'(mag3_q);
      rxm4_q <= rxm3_q;
      rym4_q <= rym3_q;
      sd4_q  <= sd3_q;
    end
  end

  // stage 5: numerator magnitudes (factor two as a shift)
  logic [cpec_pkg::NUMW-1:0] nax_q, nay_q, nbx_q, nby_q;
  logic [cpec_pkg::DENW-1:0] den5_q;
  cpec_pkg::side_t           sd5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nax_q  <= {51'(ka_q) * 51'(rxm4_q), 1'b0};
      nay_q  <= {51'(ka_q) * 51'(rym4_q), 1'b0};
      nbx_q  <= {51'(kb_q) * 51'(rxm4_q), 1'b0};
      nby_q  <= {51'(kb_q) * 51'(rym4_q), 1'b0};
      den5_q <= den4_q;
      sd5_q  <= sd4_q;
    end
  end

  logic [QW-1:0] qax, qay, qbx, qby;

  cpec_div u_div_ax (.clk_i, .en_i(en), .num_i(nax_q), .den_i(den5_q), .quo_o(qax));
  cpec_div u_div_ay (.clk_i, .en_i(en), .num_i(nay_q), .den_i(den5_q), .quo_o(qay));
  cpec_div u_div_bx (.clk_i, .en_i(en), .num_i(nbx_q), .den_i(den5_q), .quo_o(qbx));
  cpec_div u_div_by (.clk_i, .en_i(en), .num_i(nby_q), .den_i(den5_q), .quo_o(qby));

  cpec_pkg::side_t sd_q [0:QW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sd5_q;
      for (int i = 0; i < QW; i++) begin
        sd_q[i+1] <= sd_q[i];
      end
    end
  end

  // final: apply velocity change and saturate, or pass the old velocities through
  cpec_pkg::side_t    sdf;
  logic signed [21:0] dqx, dqy, wax, way, wbx, wby;
  logic signed [15:0] oax, oay, obx, oby;
  logic               cax, cay, cbx, cby;
  cpec_pkg::out_t     res;

  function automatic logic [16:0] sat16(input logic signed [21:0] v);
    logic [16:0] r;
    if (v > 22'sd32767) begin
      r = {1'b1, 16'h7fff};
    end else if (v < -22'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

  always_comb begin
    sdf = sd_q[QW];
    dqx = sdf.sx ? -$signed({2'b0, qax}) : $signed({2'b0, qax});
    dqy = sdf.sy ? -$signed({2'b0, qay}) : $signed({2'b0, qay});
    wax = {{6{sdf.axv[15]}}, sdf.axv} - dqx;
    way = {{6{sdf.ayv[15]}}, sdf.ayv} - dqy;
    dqx = sdf.sx ? -$signed({2'b0, qbx}) : $signed({2'b0, qbx});
    dqy = sdf.sy ? -$signed({2'b0, qby}) : $signed({2'b0, qby});
    wbx = {{6{sdf.bxv[15]}}, sdf.bxv} + dqx;
    wby = {{6{sdf.byv[15]}}, sdf.byv} + dqy;
    {cax, oax} = sat16(wax);
    {cay, oay} = sat16(way);
    {cbx, obx} = sat16(wbx);
    {cby, oby} = sat16(wby);
    res.hit = sdf.hit;
    if (sdf.pass) begin
      res.new_a_vel_x = sdf.axv;
      res.new_a_vel_y = sdf.ayv;
      res.new_b_vel_x = sdf.bxv;
      res.new_b_vel_y = sdf.byv;
      res.clipped     = 1'b0;
    end else begin
      res.new_a_vel_x = oax;
      res.new_a_vel_y = oay;
      res.new_b_vel_x = obx;
      res.new_b_vel_y = oby;
      res.clipped     = cax | cay | cbx | cby;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
      for (int i = 0; i <= QW; i++) begin
        vd_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      vd_q[0] <= v5_q;
      for (int i = 0; i < QW; i++) begin
        vd_q[i+1] <= vd_q[i];
      end
      vo_q    <= vd_q[QW];
    end
  end

  assign valid_o = vo_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o)
    else $error("stall raised with no item at the output");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> v1_q)
    else $error("accepted item lost at entry");

  a_miss_no_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !out_data_o.hit |-> !out_data_o.clipped)
    else $error("clip flagged without a hit");

  a_hold_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("stalled output item dropped");

endmodule
`default_nettype wire
